### rtl/core/gnbm_pkg.sv
// Package for the gated nearest-beacon match block.
// Holds shared constants, codes, state type and controller/datapath structs.
// No dependencies.
package gnbm_pkg;

   localparam int MaxReferencesDefault = 8;
   localparam int MaxCirclesDefault    = 16;

   localparam int unsigned UsedDist2    = 100000000; // 10000 mm squared
   localparam logic [13:0] GateReset    = 14'd700;

   localparam logic [1:0] OP_LOAD_BEACON = 2'd0;
   localparam logic [1:0] OP_LOAD_CIRCLE = 2'd1;
   localparam logic [1:0] OP_QUERY       = 2'd2;

   localparam logic [1:0] ST_MATCHED   = 2'd0;
   localparam logic [1:0] ST_NO_REFS   = 2'd1;
   localparam logic [1:0] ST_FEW_CIRC  = 2'd2;
   localparam logic [1:0] ST_NO_MATCH  = 2'd3;

   localparam logic [1:0] CSR_REF_COUNT = 2'd0;
   localparam logic [1:0] CSR_GATE      = 2'd1;
   localparam logic [1:0] CSR_HALF_WIN  = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CIRC_RD,
      S_WINDOW,
      S_REF_RD,
      S_DIST,
      S_CMP,
      S_DECIDE,
      S_OUT
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic start;       // latch query, reset circle index
      logic circ_next;   // advance circle index
      logic ref_clear;   // reset beacon index; best restarts at beacon 0
      logic ref_next;    // advance beacon index
      logic dist_load;   // register squared terms
      logic cmp_do;      // fold distance into best
      logic mark_used;   // mark best beacon used, build match
      logic set_status;  // build non-match result
      logic [1:0] status;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic no_refs;
      logic few_circ;
      logic circ_last;   // current circle is the last one
      logic in_window;
      logic ref_last;    // current beacon is the last one
      logic best_pass;   // best distance under gate
   } sts_type;

endpackage

### rtl/core/gnbm_if.sv
// Valid/ready channel interface carrying a payload struct.
// Depends on no package; payload type is a parameter.
interface gnbm_if #(parameter type PAYLOAD_type = logic) (input logic clock);
   logic        valid;
   logic        ready;
   PAYLOAD_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### rtl/core/gnbm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gnbm_ram #(
   parameter int Width = 16,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

### rtl/core/gnbm_ctrl.sv
// Query sequencer for the gated nearest-beacon match.
// Depends on gnbm_pkg.
module gnbm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                query_go,
   input  logic                out_free,
   input  gnbm_pkg::sts_type   sts,
   output gnbm_pkg::cmd_type   cmd,
   output logic                busy,
   output logic                out_load
);
   gnbm_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gnbm_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      out_load = 1'b0;
      case (state_ff)
         gnbm_pkg::S_IDLE: begin
            busy = 1'b0;
            if (query_go) begin
               cmd.start = 1'b1;
               state_in  = gnbm_pkg::S_CIRC_RD;
            end
         end
         gnbm_pkg::S_CIRC_RD: begin
            if (sts.no_refs) begin
               cmd.set_status = 1'b1;
               cmd.status     = gnbm_pkg::ST_NO_REFS;
               state_in       = gnbm_pkg::S_OUT;
            end else if (sts.few_circ) begin
               cmd.set_status = 1'b1;
               cmd.status     = gnbm_pkg::ST_FEW_CIRC;
               state_in       = gnbm_pkg::S_OUT;
            end else begin
               state_in = gnbm_pkg::S_WINDOW;
            end
         end
         gnbm_pkg::S_WINDOW: begin
            if (sts.in_window) begin
               cmd.ref_clear = 1'b1;
               state_in      = gnbm_pkg::S_REF_RD;
            end else if (sts.circ_last) begin
               cmd.set_status = 1'b1;
               cmd.status     = gnbm_pkg::ST_NO_MATCH;
               state_in       = gnbm_pkg::S_OUT;
            end else begin
               cmd.circ_next = 1'b1;
               state_in      = gnbm_pkg::S_CIRC_RD;
            end
         end
         gnbm_pkg::S_REF_RD: begin
            state_in = gnbm_pkg::S_DIST;
         end
         gnbm_pkg::S_DIST: begin
            cmd.dist_load = 1'b1;
            state_in      = gnbm_pkg::S_CMP;
         end
         gnbm_pkg::S_CMP: begin
            cmd.cmp_do = 1'b1;
            if (sts.ref_last) begin
               state_in = gnbm_pkg::S_DECIDE;
            end else begin
               cmd.ref_next = 1'b1;
               state_in     = gnbm_pkg::S_REF_RD;
            end
         end
         gnbm_pkg::S_DECIDE: begin
            if (sts.best_pass) begin
               cmd.mark_used = 1'b1;
               state_in      = gnbm_pkg::S_OUT;
            end else if (sts.circ_last) begin
               cmd.set_status = 1'b1;
               cmd.status     = gnbm_pkg::ST_NO_MATCH;
               state_in       = gnbm_pkg::S_OUT;
            end else begin
               cmd.circ_next = 1'b1;
               state_in      = gnbm_pkg::S_CIRC_RD;
            end
         end
         gnbm_pkg::S_OUT: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = gnbm_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = gnbm_pkg::S_IDLE;
         end
      endcase
   end
endmodule

### rtl/core/gnbm_dpath.sv
// Datapath: beacon and circle tables, used marks, window check,
// squared distance, running minimum and result build. Depends on gnbm_pkg, gnbm_ram.
module gnbm_dpath #(
   parameter int MaxReferences = gnbm_pkg::MaxReferencesDefault,
   parameter int MaxCircles    = gnbm_pkg::MaxCirclesDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              load_go,
   input  logic [1:0]        in_op,
   input  logic [3:0]        in_slot,
   input  logic [15:0]       in_x,
   input  logic [15:0]       in_y,
   input  logic [31:0]       in_time,
   input  logic [15:0]       in_range,
   input  logic [15:0]       in_bearing,
   input  logic [4:0]        in_total,
   input  logic [3:0]        ref_count,
   input  logic [13:0]       gate_mm,
   input  logic [19:0]       half_win,
   input  gnbm_pkg::cmd_type cmd,
   output gnbm_pkg::sts_type sts,
   output logic [1:0]        res_status,
   output logic [2:0]        res_index,
   output logic [15:0]       res_x,
   output logic [15:0]       res_y,
   output logic [15:0]       res_range,
   output logic [15:0]       res_bearing
);
   localparam int RW = $clog2(MaxReferences) > 0 ? $clog2(MaxReferences) : 1;
   localparam int CW = $clog2(MaxCircles);
   localparam int RN = $clog2(MaxReferences + 1);
   localparam int CN = $clog2(MaxCircles + 1);
   localparam int CIRC_W = 96;

   logic [RW-1:0] ref_idx_ff, ref_idx_in;
   logic [RW-1:0] ref_idx_sel;
   logic [CW-1:0] circ_idx_ff, circ_idx_in;
   logic [MaxReferences-1:0] used_ff, used_in;
   logic [CN-1:0] circ_cnt_ff, circ_cnt_in;
   logic [31:0] q_time_ff, q_time_in;
   logic [RN-1:0] nref;
   logic [33:0] best_ff, best_in;
   logic [RW-1:0] best_idx_ff, best_idx_in;
   logic [31:0] sqx_ff, sqy_ff;
   logic        dused_ff;
   logic [1:0]  st_ff, st_in;
   logic [2:0]  ix_ff, ix_in;
   logic [15:0] rx_ff, rx_in, ry_ff, ry_in, rr_ff, rr_in, rb_ff, rb_in;

   logic ref_wr, circ_wr;
   logic [31:0] ref_rd;
   logic [CIRC_W-1:0] circ_rd;
   logic signed [15:0] cx, cy, bx, by;
   logic [31:0] ct;
   logic signed [16:0] dx, dy;
   logic [16:0] adx, ady;
   logic [33:0] d2;
   logic [33:0] lo, hi;

   assign ref_wr  = load_go && in_op == gnbm_pkg::OP_LOAD_BEACON
                    && {1'b0, in_slot} < 5'(MaxReferences);
   assign circ_wr = load_go && in_op == gnbm_pkg::OP_LOAD_CIRCLE
                    && {3'b0, in_slot} < 7'(MaxCircles);

   // address the beacon RAM with the next index so its read data lines up with ref_idx_ff
   gnbm_ram #(.Width(32), .Depth(MaxReferences)) u_ref_ram (
      .clock(clock), .wr_en(ref_wr), .wr_addr(RW'(in_slot)),
      .wr_data({in_x, in_y}), .rd_addr(ref_idx_sel), .rd_data(ref_rd));

   gnbm_ram #(.Width(CIRC_W), .Depth(MaxCircles)) u_circ_ram (
      .clock(clock), .wr_en(circ_wr), .wr_addr(CW'(in_slot)),
      .wr_data({in_x, in_y, in_time, in_range, in_bearing}),
      .rd_addr(circ_idx_ff), .rd_data(circ_rd));

   assign cx = circ_rd[95:80];
   assign cy = circ_rd[79:64];
   assign ct = circ_rd[63:32];
   assign bx = ref_rd[31:16];
   assign by = ref_rd[15:0];

   assign nref = ({1'b0, ref_count} > 5'(MaxReferences)) ? RN'(MaxReferences)
                                                       : RN'(ref_count);

   // window ct - hw < t <= ct + hw, full precision
   assign lo = {2'b0, q_time_ff} + 34'(half_win);
   assign hi = {2'b0, ct} + 34'(half_win);

   assign dx  = 17'(cx) - 17'(bx);
   assign dy  = 17'(cy) - 17'(by);
   assign adx = dx[16] ? 17'(-dx) : 17'(dx);
   assign ady = dy[16] ? 17'(-dy) : 17'(dy);
   assign d2  = dused_ff ? 34'(gnbm_pkg::UsedDist2) : 34'(sqx_ff) + 34'(sqy_ff);

   assign sts.no_refs   = nref == '0;
   assign sts.few_circ  = circ_cnt_ff < CN'(2);
   assign sts.circ_last = CN'(circ_idx_ff) + CN'(1) >= circ_cnt_ff;
   assign sts.in_window = ({2'b0, q_time_ff} <= hi) && ({2'b0, ct} < lo);
   assign sts.ref_last  = RN'(ref_idx_ff) + RN'(1) >= nref;
   assign sts.best_pass = best_ff < 34'(28'(gate_mm) * 28'(gate_mm));

   always_comb begin
      ref_idx_in  = ref_idx_ff;
      circ_idx_in = circ_idx_ff;
      used_in     = used_ff;
      circ_cnt_in = circ_cnt_ff;
      q_time_in   = q_time_ff;
      best_in     = best_ff;
      best_idx_in = best_idx_ff;
      st_in = st_ff; ix_in = ix_ff; rx_in = rx_ff; ry_in = ry_ff;
      rr_in = rr_ff; rb_in = rb_ff;
      if (load_go && in_op == gnbm_pkg::OP_LOAD_CIRCLE) begin
         circ_cnt_in = ({2'b0, in_total} > 7'(MaxCircles)) ? CN'(MaxCircles)
                                                           : CN'(in_total);
         if (in_slot == '0) begin
            used_in = '0;
         end
      end
      if (cmd.start) begin
         q_time_in   = in_time;
         circ_idx_in = '0;
      end
      if (cmd.circ_next) begin
         circ_idx_in = circ_idx_ff + CW'(1);
      end
      if (cmd.ref_clear) begin
         ref_idx_in = '0;
      end
      if (cmd.ref_next) begin
         ref_idx_in = ref_idx_ff + RW'(1);
      end
      if (cmd.cmp_do) begin
         if (ref_idx_ff == '0 || d2 < best_ff) begin
            best_in     = d2;
            best_idx_in = ref_idx_ff;
         end
      end
      if (cmd.mark_used) begin
         used_in[best_idx_ff] = 1'b1;
         st_in = gnbm_pkg::ST_MATCHED;
         ix_in = 3'(best_idx_ff);
         rx_in = bx;
         ry_in = by;
         rr_in = circ_rd[31:16];
         rb_in = circ_rd[15:0];
      end
      if (cmd.set_status) begin
         st_in = cmd.status;
         ix_in = '0; rx_in = '0; ry_in = '0; rr_in = '0; rb_in = '0;
      end
   end

   // in DECIDE the beacon RAM must present the best beacon
   assign ref_idx_sel = (cmd.cmp_do && !cmd.ref_next) ? best_idx_in : ref_idx_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff     <= '0;
         circ_cnt_ff <= '0;
      end else begin
         used_ff     <= used_in;
         circ_cnt_ff <= circ_cnt_in;
      end
      ref_idx_ff  <= ref_idx_sel;
      circ_idx_ff <= circ_idx_in;
      q_time_ff   <= q_time_in;
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
      if (cmd.dist_load) begin
         sqx_ff   <= 32'(adx) * 32'(adx);
         sqy_ff   <= 32'(ady) * 32'(ady);
         dused_ff <= used_ff[ref_idx_ff];
      end
      st_ff <= st_in; ix_ff <= ix_in; rx_ff <= rx_in; ry_ff <= ry_in;
      rr_ff <= rr_in; rb_ff <= rb_in;
   end

   assign res_status  = st_ff;
   assign res_index   = ix_ff;
   assign res_x       = rx_ff;
   assign res_y       = ry_ff;
   assign res_range   = rr_ff;
   assign res_bearing = rb_ff;
endmodule

### rtl/core/gated_nearest_beacon_match_top.sv
// Top level of the gated nearest-beacon match block.
// Depends on gnbm_pkg, gnbm_if, gnbm_ram, gnbm_ctrl, gnbm_dpath.
//
//   channel | direction | content
//   req     | in        | load beacon, load circle or query beat
//   rsp     | out       | one result beat per query
//   csr     | in        | register write: ref count, gate, half window
//
// A load beat is written as it is taken. A query is accepted, then each circle is
// read and window checked; for each circle inside the time window every beacon is
// read, squared and compared one at a time (shared squarer pair, single beacon RAM
// port), then the best is decided against the gate and the result is loaded.
// Reset is synchronous: it idles the sequencer, clears the used marks, circle
// count, ref count, half window and rsp valid, and sets the gate to GateReset.
// The result sits in an output register; a stalled rsp holds it, loads and the
// next query go on, and a finished query waits until the earlier beat leaves.
module gated_nearest_beacon_match_top #(
   parameter int MaxReferences = gnbm_pkg::MaxReferencesDefault,
   parameter int MaxCircles    = gnbm_pkg::MaxCirclesDefault
) (
   input  logic        clock,
   input  logic        reset,
   gnbm_if.sink        req,
   gnbm_if.source      rsp,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [19:0] csr_write_data
);
   logic [3:0]  ref_count_ff;
   logic [13:0] gate_ff;
   logic [19:0] half_win_ff;

   // write registers; unknown indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         ref_count_ff <= '0;
         gate_ff      <= gnbm_pkg::GateReset;
         half_win_ff  <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            gnbm_pkg::CSR_REF_COUNT: ref_count_ff <= csr_write_data[3:0];
            gnbm_pkg::CSR_GATE:      gate_ff      <= csr_write_data[13:0];
            gnbm_pkg::CSR_HALF_WIN:  half_win_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   gnbm_pkg::cmd_type cmd;
   gnbm_pkg::sts_type sts;
   logic busy, out_load, req_fire, query_go;
   logic rsp_valid_ff;
   logic [1:0] st;
   logic [2:0] ix;
   logic [15:0] bx, by, mr, mb;

   // take a beat whenever the sequencer is idle; the output register parts the sides
   assign req.ready = !busy;
   assign req_fire  = req.valid && req.ready;
   assign query_go  = req_fire && req.payload.operation == gnbm_pkg::OP_QUERY;

   gnbm_ctrl u_ctrl (
      .clock(clock), .reset(reset), .query_go(query_go),
      .out_free(!rsp_valid_ff), .sts(sts), .cmd(cmd),
      .busy(busy), .out_load(out_load));

   gnbm_dpath #(.MaxReferences(MaxReferences), .MaxCircles(MaxCircles)) u_dpath (
      .clock(clock), .reset(reset), .load_go(req_fire),
      .in_op(req.payload.operation), .in_slot(req.payload.slot),
      .in_x(req.payload.pos_x), .in_y(req.payload.pos_y),
      .in_time(req.payload.time_stamp), .in_range(req.payload.range_mm),
      .in_bearing(req.payload.bearing), .in_total(req.payload.total_circles),
      .ref_count(ref_count_ff), .gate_mm(gate_ff), .half_win(half_win_ff),
      .cmd(cmd), .sts(sts), .res_status(st), .res_index(ix),
      .res_x(bx), .res_y(by), .res_range(mr), .res_bearing(mb));

   // output register: hold until the beat is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (out_load) begin
         rsp.payload.status       <= st;
         rsp.payload.beacon_index <= ix;
         rsp.payload.beacon_x     <= bx;
         rsp.payload.beacon_y     <= by;
         rsp.payload.meas_range   <= mr;
         rsp.payload.meas_bearing <= mb;
      end
   end
   assign rsp.valid = rsp_valid_ff;

`ifndef SYNTH
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !req.ready) else $error("request taken while busy");
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      out_load |-> !rsp_valid_ff) else $error("result overwritten");
   a_query_result: assert property (@(posedge clock) disable iff (reset)
      query_go |=> busy) else $error("query lost");
   a_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.payload.status != gnbm_pkg::ST_MATCHED
      |-> rsp.payload.beacon_x == '0 && rsp.payload.meas_range == '0)
      else $error("non-match fields not zero");
`endif
endmodule
